FILE: rtl/core/crvg_pkg.sv
// Shared types, constants and tables for the circle ring vertex generator.
package crvg_pkg;

  localparam int MAX_SEGMENTS  = 1024;
  localparam int CORDIC_STAGES = 16;
  localparam int PHASE_BITS    = 32;
  localparam int XW            = 36;
  localparam int ZW            = 33;
  localparam int IW            = 10;
  localparam int NW            = 11;
  localparam int EW            = 12;
  localparam int OW            = 17;
  localparam int OUT_LIMIT     = 65535;
  localparam logic [15:0] GAIN_Q16 = 16'd39797;

  localparam logic CFG_RADIUS   = 1'b0;
  localparam logic CFG_SEGMENTS = 1'b1;

  typedef struct packed {
    logic          valid;
    logic          err;
    logic          zero_div;
    logic [IW-1:0] idx;
    logic [NW-1:0] d;
    logic [NW-1:0] r;
    logic [PHASE_BITS-1:0] q;
    logic signed [XW-1:0] x0;
  } div_t;

  typedef struct packed {
    logic          valid;
    logic          err;
    logic [IW-1:0] idx;
    logic [1:0]    quad;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    case (k)
      5'd0:  atan_turns = 32'h20000000;
      5'd1:  atan_turns = 32'h12E4051D;
      5'd2:  atan_turns = 32'h09FB385B;
      5'd3:  atan_turns = 32'h051111D4;
      5'd4:  atan_turns = 32'h028B0D43;
      5'd5:  atan_turns = 32'h0145D7E1;
      5'd6:  atan_turns = 32'h00A2F61E;
      5'd7:  atan_turns = 32'h00517C55;
      5'd8:  atan_turns = 32'h0028BE53;
      5'd9:  atan_turns = 32'h00145F2F;
      5'd10: atan_turns = 32'h000A2F98;
      5'd11: atan_turns = 32'h000517CC;
      5'd12: atan_turns = 32'h00028BE6;
      5'd13: atan_turns = 32'h000145F3;
      5'd14: atan_turns = 32'h0000A2FA;
      5'd15: atan_turns = 32'h0000517D;
      5'd16: atan_turns = 32'h000028BE;
      5'd17: atan_turns = 32'h0000145F;
      5'd18: atan_turns = 32'h00000A30;
      5'd19: atan_turns = 32'h00000518;
      5'd20: atan_turns = 32'h0000028C;
      5'd21: atan_turns = 32'h00000146;
      5'd22: atan_turns = 32'h000000A3;
      5'd23: atan_turns = 32'h00000051;
      default: atan_turns = 32'h0;
    endcase
  endfunction

endpackage

FILE: rtl/core/crvg_div_cell.sv
// One restoring-division cell: produces one phase fraction bit per cycle.
module crvg_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  crvg_pkg::div_t din,
  output crvg_pkg::div_t dout
);

  logic [crvg_pkg::NW:0]   r2;
  logic                    bit_q;
  crvg_pkg::div_t          nxt;

  always_comb begin
    r2    = {din.r, 1'b0};
    bit_q = (r2 >= {1'b0, din.d});
    nxt   = din;
    nxt.valid = din.valid && !rst;
    nxt.q = {din.q[crvg_pkg::PHASE_BITS-2:0], bit_q};
    nxt.r = bit_q ? crvg_pkg::NW'(r2 - {1'b0, din.d}) : crvg_pkg::NW'(r2);
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

FILE: rtl/core/crvg_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation per cycle.
module crvg_cordic_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic [4:0]      k,
  input  crvg_pkg::cord_t din,
  output crvg_pkg::cord_t dout
);

  logic signed [crvg_pkg::XW-1:0] dx;
  logic signed [crvg_pkg::XW-1:0] dy;
  logic signed [crvg_pkg::ZW-1:0] a;
  crvg_pkg::cord_t                nxt;

  always_comb begin
    dx  = din.y >>> k;
    dy  = din.x >>> k;
    a   = $signed({1'b0, crvg_pkg::atan_turns(k)});
    nxt = din;
    nxt.valid = din.valid && !rst;
    if (!din.z[crvg_pkg::ZW-1]) begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - a;
    end else begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + a;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

FILE: rtl/core/circle_ring_vertex_generator.sv
// Top level of the circle ring vertex generator: divider chain, CORDIC chain, output stage.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  request   | start / busy              | segment_index
//  config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//  result    | done (one-cycle strobe)   | x_coord, y_coord, ringK_edge_*, index_error
//
// A request is accepted every cycle; busy is always low. Each result passes
// through one input stage (count clamp and the radius times gain multiply),
// 32 divider cells that each yield one phase bit, 16 CORDIC cells that each
// do one micro-rotation, and one output stage that applies the quadrant,
// rounds and saturates. Throughput is one request per cycle, set by the cell
// chains. Reset clears the valid bits of every stage and loads radius 256 and
// segment count 16. The receiver cannot stall, so nothing ever backs up. The
// user must change configuration only while the pipeline is empty, as later
// stages read the live registers; the block itself does not enforce this.
module circle_ring_vertex_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  segment_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic signed [16:0] x_coord,
  output logic signed [16:0] y_coord,
  output logic [11:0] ring0_edge_from,
  output logic [11:0] ring0_edge_to,
  output logic [11:0] ring1_edge_from,
  output logic [11:0] ring1_edge_to,
  output logic [11:0] ring2_edge_from,
  output logic [11:0] ring2_edge_to,
  output logic        index_error
);

  localparam int NDIV = crvg_pkg::PHASE_BITS;
  localparam int NCOR = crvg_pkg::CORDIC_STAGES;

  logic [15:0]                 radius;
  logic [crvg_pkg::NW-1:0]     segment_count;
  logic [crvg_pkg::NW-1:0]     n_eff;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= 16'd256;
      segment_count <= crvg_pkg::NW'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crvg_pkg::CFG_RADIUS:   radius        <= cfg_data;
        crvg_pkg::CFG_SEGMENTS: segment_count <= cfg_data[crvg_pkg::NW-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (segment_count > crvg_pkg::NW'(crvg_pkg::MAX_SEGMENTS)) ?
                 crvg_pkg::NW'(crvg_pkg::MAX_SEGMENTS) : segment_count;

  // Input stage: divisor is n-1, the integer quotient bit is removed up front.
  crvg_pkg::div_t div_in;
  crvg_pkg::div_t div_chain [NDIV+1];
  logic [crvg_pkg::NW-1:0] d_in;
  logic [crvg_pkg::NW-1:0] i_ext;

  always_comb begin
    d_in  = n_eff - crvg_pkg::NW'(1);
    i_ext = {1'b0, segment_index};
  end

  always_ff @(posedge clk) begin
    div_in.err      <= (i_ext >= n_eff);
    div_in.zero_div <= (n_eff <= crvg_pkg::NW'(1));
    div_in.idx      <= segment_index;
    div_in.d        <= d_in;
    div_in.r        <= (i_ext >= d_in) ? crvg_pkg::NW'(i_ext - d_in) : i_ext;
    div_in.q        <= '0;
    div_in.x0       <= $signed(crvg_pkg::XW'({20'd0, radius} * {20'd0, crvg_pkg::GAIN_Q16}));
    div_in.valid    <= rst ? 1'b0 : start && !busy;
  end

  assign div_chain[0] = div_in;

  genvar g;
  generate
    for (g = 0; g < NDIV; g++) begin : g_div
      crvg_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .din  (div_chain[g]),
        .dout (div_chain[g+1])
      );
    end
  endgenerate

  // Hand over to the CORDIC chain: quadrant from the top phase bits.
  crvg_pkg::cord_t cor_chain [NCOR+1];
  crvg_pkg::div_t  dl;
  logic [NDIV-1:0] phase;

  always_comb begin
    dl    = div_chain[NDIV];
    phase = dl.zero_div ? '0 : dl.q;
    cor_chain[0].valid = dl.valid;
    cor_chain[0].err   = dl.err;
    cor_chain[0].idx   = dl.idx;
    cor_chain[0].quad  = phase[NDIV-1:NDIV-2];
    cor_chain[0].x     = dl.x0;
    cor_chain[0].y     = '0;
    cor_chain[0].z     = $signed({3'b000, phase[NDIV-3:0]});
  end

  generate
    for (g = 0; g < NCOR; g++) begin : g_cor
      crvg_cordic_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .k    (5'(g)),
        .din  (cor_chain[g]),
        .dout (cor_chain[g+1])
      );
    end
  endgenerate

  // Output stage: quadrant turn, round half up, saturate, edge indices.
  crvg_pkg::cord_t cl;
  logic signed [crvg_pkg::XW-1:0] cx;
  logic signed [crvg_pkg::XW-1:0] sy;
  logic signed [crvg_pkg::OW-1:0] xq;
  logic signed [crvg_pkg::OW-1:0] yq;
  logic [crvg_pkg::EW-1:0] b1, b2, ie, f0, f1, f2, t0, t1, t2;
  logic wrap;

  function automatic logic signed [16:0] to_q88(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [19:0] r;
    t = v + 36'sd32768;
    r = 20'(t >>> 16);
    if (r > 20'sd65535)       to_q88 = 17'sd65535;
    else if (r < -20'sd65535) to_q88 = -17'sd65535;
    else                      to_q88 = 17'(r);
  endfunction

  always_comb begin
    cl = cor_chain[NCOR];
    case (cl.quad)
      2'd1:    begin cx = -cl.y; sy = cl.x;  end
      2'd2:    begin cx = -cl.x; sy = -cl.y; end
      2'd3:    begin cx = cl.y;  sy = -cl.x; end
      default: begin cx = cl.x;  sy = cl.y;  end
    endcase
    xq   = to_q88(cx);
    yq   = to_q88(sy);
    b1   = crvg_pkg::EW'(n_eff);
    b2   = crvg_pkg::EW'({n_eff, 1'b0});
    ie   = crvg_pkg::EW'(cl.idx);
    wrap = ({1'b0, ie} + 13'd1) >= {2'b00, n_eff};
    f0   = ie;
    f1   = b1 + ie;
    f2   = b2 + ie;
    t0   = wrap ? '0 : f0 + 12'd1;
    t1   = wrap ? b1 : f1 + 12'd1;
    t2   = wrap ? b2 : f2 + 12'd1;
  end

  always_ff @(posedge clk) begin
    done            <= rst ? 1'b0 : cl.valid;
    index_error     <= cl.err;
    x_coord         <= cl.err ? '0 : xq;
    y_coord         <= cl.err ? '0 : yq;
    ring0_edge_from <= cl.err ? '0 : f0;
    ring0_edge_to   <= cl.err ? '0 : t0;
    ring1_edge_from <= cl.err ? '0 : f1;
    ring1_edge_to   <= cl.err ? '0 : t1;
    ring2_edge_from <= cl.err ? '0 : f2;
    ring2_edge_to   <= cl.err ? '0 : t2;
  end

endmodule

FILE: rtl/core/crvg_checker.sv
// Port-level assertions for the circle ring vertex generator, bound to the top level.
module crvg_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic signed [16:0] x_coord,
  input logic signed [16:0] y_coord,
  input logic [11:0] ring0_edge_from,
  input logic [11:0] ring0_edge_to,
  input logic        index_error
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && index_error |-> x_coord == 0 && y_coord == 0 && ring0_edge_from == 0)
    else $error("error result carries data");

  a_edge_step: assert property (@(posedge clk) disable iff (rst)
    done && !index_error |-> ring0_edge_to == 0 || ring0_edge_to == ring0_edge_from + 12'd1)
    else $error("ring zero edge broken");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> x_coord != -17'sd65536 && y_coord != -17'sd65536)
    else $error("coordinate out of range");

endmodule

bind circle_ring_vertex_generator crvg_checker u_crvg_checker (
  .clk             (clk),
  .rst             (rst),
  .busy            (busy),
  .done            (done),
  .x_coord         (x_coord),
  .y_coord         (y_coord),
  .ring0_edge_from (ring0_edge_from),
  .ring0_edge_to   (ring0_edge_to),
  .index_error     (index_error)
);
